// ----- rtl/ray_triangle_hit_test_unit_defines.svh -----
// Assertion macros for the checker file of the ray/triangle hit test unit.
`ifndef RAY_TRIANGLE_HIT_TEST_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_HIT_TEST_UNIT_DEFINES_SVH

// Checked only while reset is released.
`define RTH_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define RTH_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/rth_pkg.sv -----
// Shared widths, types and constant multipliers of the ray/triangle hit test unit.
`default_nettype none

package rth_pkg;

    localparam int COORD_W     = 32;
    localparam int EDGE_W      = COORD_W + 1;
    localparam int H_W         = 58;
    localparam int H_LO_W      = 29;
    localparam int Q_W         = 2 * EDGE_W;
    localparam int Q_LO_W      = EDGE_W;
    localparam int ACC_W       = 104;
    localparam int DIR_X_SHIFT = 24;

    localparam int AH_W = EDGE_W + H_W - H_LO_W;
    localparam int AL_W = EDGE_W + H_LO_W + 1;
    localparam int TH_W = EDGE_W + Q_W - Q_LO_W;
    localparam int TL_W = EDGE_W + Q_LO_W + 1;

    localparam int IDX_X = 0;
    localparam int IDX_Y = 1;
    localparam int IDX_Z = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [EDGE_W-1:0]  t_edge;
    typedef logic signed [H_W-1:0]     t_hval;
    typedef logic signed [Q_W-1:0]     t_qval;
    typedef logic signed [ACC_W-1:0]   t_acc;

    typedef struct packed {
        t_acc a;
        t_acc u;
        t_acc v;
        t_acc t0;
        t_acc t1;
        t_acc t2;
    } t_sums;

    // Multiplies by the y component of the ray direction, 2852.
    function automatic t_acc mul_dir_y(input t_acc x);
        return (x <<< 11) + (x <<< 9) + (x <<< 8) + (x <<< 5) + (x <<< 2);
    endfunction

    // Multiplies by the z component of the ray direction, 5201.
    function automatic t_acc mul_dir_z(input t_acc x);
        return (x <<< 12) + (x <<< 10) + (x <<< 6) + (x <<< 4) + x;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ray_triangle_hit_test_unit.sv -----
// Top level of the ray/triangle hit test unit: exact division-free Moller-Trumbore test.
// The unit accepts one request per clock cycle while the output side does not stall,
// and returns its hit flag through the seven register stages of the arithmetic
// pipeline; a stalled output holds its result while empty stages further back keep
// taking new requests. All arithmetic is exact integer arithmetic on the Q16.16
// inputs, with multipliers of at most 33 by 34 bits split out of the wide products.
// A hit is reported when the fixed skewed +X ray leaves the origin and crosses the
// triangle strictly ahead of it; edges and corners count as hits, and degenerate or
// edge-on triangles always miss.
`default_nettype none

module ray_triangle_hit_test_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_origin_x,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_origin_y,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_origin_z,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert0_x,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert0_y,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert0_z,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert1_x,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert1_y,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert1_z,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert2_x,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert2_y,
    input  logic signed [rth_pkg::COORD_W-1:0]  i_vert2_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit
);

    localparam int AH_W = rth_pkg::AH_W;
    localparam int AL_W = rth_pkg::AL_W;
    localparam int TH_W = rth_pkg::TH_W;
    localparam int TL_W = rth_pkg::TL_W;

    rth_pkg::t_coord w_org [3];
    rth_pkg::t_coord w_v0  [3];
    rth_pkg::t_coord w_v1  [3];
    rth_pkg::t_coord w_v2  [3];

    logic [5:1] w_en;
    logic [5:1] r_v;
    logic       w_dec_ready;

    rth_pkg::t_edge r1_e1 [3];
    rth_pkg::t_edge r1_e2 [3];
    rth_pkg::t_edge r1_s  [3];

    rth_pkg::t_edge r2_e1 [3];
    rth_pkg::t_edge r2_e2 [3];
    rth_pkg::t_edge r2_s  [3];
    rth_pkg::t_hval r2_h  [3];
    rth_pkg::t_hval n2_h  [3];
    rth_pkg::t_qval r2_pa [3];
    rth_pkg::t_qval r2_pb [3];

    rth_pkg::t_edge         r3_e2  [3];
    rth_pkg::t_qval         r3_q   [3];
    logic signed [AH_W-1:0] r3_ahi [3];
    logic signed [AL_W-1:0] r3_alo [3];
    logic signed [AH_W-1:0] r3_uhi [3];
    logic signed [AL_W-1:0] r3_ulo [3];

    rth_pkg::t_acc          r4_am  [3];
    rth_pkg::t_acc          r4_um  [3];
    rth_pkg::t_acc          r4_vm  [3];
    logic signed [TH_W-1:0] r4_thi [3];
    logic signed [TL_W-1:0] r4_tlo [3];

    rth_pkg::t_sums r5_sums;

    assign w_org = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_v0  = '{i_vert0_x, i_vert0_y, i_vert0_z};
    assign w_v1  = '{i_vert1_x, i_vert1_y, i_vert1_z};
    assign w_v2  = '{i_vert2_x, i_vert2_y, i_vert2_z};

    always_comb begin
        w_en[5] = !r_v[5] || w_dec_ready;
        for (int k = 4; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 5; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: triangle edges and the origin relative to the first corner.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= rth_pkg::t_edge'(w_v1[k]) - rth_pkg::t_edge'(w_v0[k]);
                r1_e2[k] <= rth_pkg::t_edge'(w_v2[k]) - rth_pkg::t_edge'(w_v0[k]);
                r1_s[k]  <= rth_pkg::t_edge'(w_org[k]) - rth_pkg::t_edge'(w_v0[k]);
            end
        end
    end

    // Stage 2: h = dir x e2 by constant shifts, and the products of q = s x e1.
    always_comb begin
        n2_h[rth_pkg::IDX_X] = rth_pkg::t_hval'(
            rth_pkg::mul_dir_y(rth_pkg::t_acc'(r1_e2[rth_pkg::IDX_Z])) -
            rth_pkg::mul_dir_z(rth_pkg::t_acc'(r1_e2[rth_pkg::IDX_Y])));
        n2_h[rth_pkg::IDX_Y] = rth_pkg::t_hval'(
            rth_pkg::mul_dir_z(rth_pkg::t_acc'(r1_e2[rth_pkg::IDX_X])) -
            (rth_pkg::t_acc'(r1_e2[rth_pkg::IDX_Z]) <<< rth_pkg::DIR_X_SHIFT));
        n2_h[rth_pkg::IDX_Z] = rth_pkg::t_hval'(
            (rth_pkg::t_acc'(r1_e2[rth_pkg::IDX_Y]) <<< rth_pkg::DIR_X_SHIFT) -
            rth_pkg::mul_dir_y(rth_pkg::t_acc'(r1_e2[rth_pkg::IDX_X])));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_h  <= n2_h;
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_s  <= r1_s;
            r2_pa[rth_pkg::IDX_X] <= rth_pkg::t_qval'(r1_s[rth_pkg::IDX_Y]) *
                                     rth_pkg::t_qval'(r1_e1[rth_pkg::IDX_Z]);
            r2_pb[rth_pkg::IDX_X] <= rth_pkg::t_qval'(r1_s[rth_pkg::IDX_Z]) *
                                     rth_pkg::t_qval'(r1_e1[rth_pkg::IDX_Y]);
            r2_pa[rth_pkg::IDX_Y] <= rth_pkg::t_qval'(r1_s[rth_pkg::IDX_Z]) *
                                     rth_pkg::t_qval'(r1_e1[rth_pkg::IDX_X]);
            r2_pb[rth_pkg::IDX_Y] <= rth_pkg::t_qval'(r1_s[rth_pkg::IDX_X]) *
                                     rth_pkg::t_qval'(r1_e1[rth_pkg::IDX_Z]);
            r2_pa[rth_pkg::IDX_Z] <= rth_pkg::t_qval'(r1_s[rth_pkg::IDX_X]) *
                                     rth_pkg::t_qval'(r1_e1[rth_pkg::IDX_Y]);
            r2_pb[rth_pkg::IDX_Z] <= rth_pkg::t_qval'(r1_s[rth_pkg::IDX_Y]) *
                                     rth_pkg::t_qval'(r1_e1[rth_pkg::IDX_X]);
        end
    end

    // Stage 3: q, and the split partial products of e1.h and s.h.
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_e2 <= r2_e2;
            for (int k = 0; k < 3; k++) begin
                r3_q[k]   <= r2_pa[k] - r2_pb[k];
                r3_ahi[k] <= AH_W'(r2_e1[k]) *
                             AH_W'($signed(r2_h[k][rth_pkg::H_W-1:rth_pkg::H_LO_W]));
                r3_alo[k] <= AL_W'(r2_e1[k]) *
                             AL_W'($signed({1'b0, r2_h[k][rth_pkg::H_LO_W-1:0]}));
                r3_uhi[k] <= AH_W'(r2_s[k]) *
                             AH_W'($signed(r2_h[k][rth_pkg::H_W-1:rth_pkg::H_LO_W]));
                r3_ulo[k] <= AL_W'(r2_s[k]) *
                             AL_W'($signed({1'b0, r2_h[k][rth_pkg::H_LO_W-1:0]}));
            end
        end
    end

    // Stage 4: recombine a and u terms, split e2.q, and dir.q terms by constants.
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r4_am[k]  <= (rth_pkg::t_acc'(r3_ahi[k]) <<< rth_pkg::H_LO_W) +
                             rth_pkg::t_acc'(r3_alo[k]);
                r4_um[k]  <= (rth_pkg::t_acc'(r3_uhi[k]) <<< rth_pkg::H_LO_W) +
                             rth_pkg::t_acc'(r3_ulo[k]);
                r4_thi[k] <= TH_W'(r3_e2[k]) *
                             TH_W'($signed(r3_q[k][rth_pkg::Q_W-1:rth_pkg::Q_LO_W]));
                r4_tlo[k] <= TL_W'(r3_e2[k]) *
                             TL_W'($signed({1'b0, r3_q[k][rth_pkg::Q_LO_W-1:0]}));
            end
            r4_vm[rth_pkg::IDX_X] <= rth_pkg::t_acc'(r3_q[rth_pkg::IDX_X]) <<<
                                     rth_pkg::DIR_X_SHIFT;
            r4_vm[rth_pkg::IDX_Y] <= rth_pkg::mul_dir_y(rth_pkg::t_acc'(r3_q[rth_pkg::IDX_Y]));
            r4_vm[rth_pkg::IDX_Z] <= rth_pkg::mul_dir_z(rth_pkg::t_acc'(r3_q[rth_pkg::IDX_Z]));
        end
    end

    // Stage 5: the determinant and barycentric sums, and recombined e2.q terms.
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_sums.a  <= r4_am[0] + r4_am[1] + r4_am[2];
            r5_sums.u  <= r4_um[0] + r4_um[1] + r4_um[2];
            r5_sums.v  <= r4_vm[0] + r4_vm[1] + r4_vm[2];
            r5_sums.t0 <= (rth_pkg::t_acc'(r4_thi[0]) <<< rth_pkg::Q_LO_W) +
                          rth_pkg::t_acc'(r4_tlo[0]);
            r5_sums.t1 <= (rth_pkg::t_acc'(r4_thi[1]) <<< rth_pkg::Q_LO_W) +
                          rth_pkg::t_acc'(r4_tlo[1]);
            r5_sums.t2 <= (rth_pkg::t_acc'(r4_thi[2]) <<< rth_pkg::Q_LO_W) +
                          rth_pkg::t_acc'(r4_tlo[2]);
        end
    end

    rth_decide u_rth_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[5]),
        .o_ready (w_dec_ready),
        .i_sums  (r5_sums),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hit   (o_hit)
    );

endmodule

`default_nettype wire

// ----- rtl/rth_decide.sv -----
// Final two pipeline stages: sign-aware range checks that produce the hit flag.
`default_nettype none

module rth_decide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rth_pkg::t_sums i_sums,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_hit
);

    localparam int MSB = rth_pkg::ACC_W - 1;

    logic w_en6;
    logic w_en7;
    logic r_v6;
    logic r_v7;

    rth_pkg::t_acc r6_a;
    rth_pkg::t_acc r6_uv;
    rth_pkg::t_acc r6_t;
    logic          r6_u_neg;
    logic          r6_u_zero;
    logic          r6_v_neg;
    logic          r6_v_zero;
    logic          r7_hit;

    rth_pkg::t_acc n7_d;
    logic          n7_a_pos;
    logic          n7_a_neg;
    logic          n7_t_pos;
    logic          n7_t_neg;
    logic          n7_d_neg;
    logic          n7_d_zero;
    logic          n7_hit;

    assign w_en7   = !r_v7 || i_ready;
    assign w_en6   = !r_v6 || w_en7;
    assign o_ready = w_en6;
    assign o_valid = r_v7;
    assign o_hit   = r7_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (w_en6) begin
                r_v6 <= i_valid;
            end
            if (w_en7) begin
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r6_a      <= i_sums.a;
            r6_uv     <= i_sums.u + i_sums.v;
            r6_t      <= i_sums.t0 + i_sums.t1 + i_sums.t2;
            r6_u_neg  <= i_sums.u[MSB];
            r6_u_zero <= (i_sums.u == '0);
            r6_v_neg  <= i_sums.v[MSB];
            r6_v_zero <= (i_sums.v == '0);
        end
    end

    // For a negative determinant every comparison flips direction.
    always_comb begin
        n7_d      = r6_a - r6_uv;
        n7_d_neg  = n7_d[MSB];
        n7_d_zero = (r6_a == r6_uv);
        n7_a_neg  = r6_a[MSB];
        n7_a_pos  = !r6_a[MSB] && (r6_a != '0);
        n7_t_neg  = r6_t[MSB];
        n7_t_pos  = !r6_t[MSB] && (r6_t != '0);
        n7_hit    = (n7_a_pos && !r6_u_neg && !r6_v_neg && !n7_d_neg && n7_t_pos) ||
                    (n7_a_neg && (r6_u_neg || r6_u_zero) && (r6_v_neg || r6_v_zero) &&
                     (n7_d_neg || n7_d_zero) && n7_t_neg);
    end

    always_ff @(posedge i_clk) begin
        if (w_en7) begin
            r7_hit <= n7_hit;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rth_checker.sv -----
// Port-level assertions for the ray/triangle hit test unit, bound to its top level.
`default_nettype none

`include "ray_triangle_hit_test_unit_defines.svh"

module rth_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_hit
);

    `RTH_CHECK_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid, "output valid after reset")
    `RTH_CHECK(a_empty_out_ready, !o_valid |-> o_ready, "not ready while output is empty")
    `RTH_CHECK(a_busy_only_stalled, !o_ready |-> (o_valid && !i_ready), "busy without stall")
    `RTH_CHECK(a_out_holds, (o_valid && !i_ready) |=> (o_valid && $stable(o_hit)), "result lost")

endmodule

bind ray_triangle_hit_test_unit rth_checker u_rth_checker (.*);

`default_nettype wire

// ----- tb/ray_triangle_hit_checker.sv -----
// Request and result monitor for the ray/triangle hit test unit, with an exact hit predictor.
`timescale 1ns / 100ps

module ray_triangle_hit_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  rth_pkg::t_coord i_origin_x,
    input  rth_pkg::t_coord i_origin_y,
    input  rth_pkg::t_coord i_origin_z,
    input  rth_pkg::t_coord i_vert0_x,
    input  rth_pkg::t_coord i_vert0_y,
    input  rth_pkg::t_coord i_vert0_z,
    input  rth_pkg::t_coord i_vert1_x,
    input  rth_pkg::t_coord i_vert1_y,
    input  rth_pkg::t_coord i_vert1_z,
    input  rth_pkg::t_coord i_vert2_x,
    input  rth_pkg::t_coord i_vert2_y,
    input  rth_pkg::t_coord i_vert2_z,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  logic            i_hit,
    output int              o_fail_count,
    output int              o_pending_count
);

    typedef logic signed [127:0] t_wide;

    localparam t_wide RAY_DIR_X = 16777216;
    localparam t_wide RAY_DIR_Y = 2852;
    localparam t_wide RAY_DIR_Z = 5201;

    logic expected_hits[$];
    int   mismatch_count;

    // All products are formed exactly in 128 bits, so the sign tests below are exact.
    function automatic logic ray_hits_triangle(
        input rth_pkg::t_coord ox, oy, oz,
        input rth_pkg::t_coord ax, ay, az,
        input rth_pkg::t_coord bx, by, bz,
        input rth_pkg::t_coord cx, cy, cz
    );
        t_wide e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
        t_wide hx, hy, hz, qx, qy, qz;
        t_wide det, bary_u, bary_v, depth;
        e1x = t_wide'(bx) - t_wide'(ax);
        e1y = t_wide'(by) - t_wide'(ay);
        e1z = t_wide'(bz) - t_wide'(az);
        e2x = t_wide'(cx) - t_wide'(ax);
        e2y = t_wide'(cy) - t_wide'(ay);
        e2z = t_wide'(cz) - t_wide'(az);
        sx  = t_wide'(ox) - t_wide'(ax);
        sy  = t_wide'(oy) - t_wide'(ay);
        sz  = t_wide'(oz) - t_wide'(az);
        hx  = RAY_DIR_Y * e2z - RAY_DIR_Z * e2y;
        hy  = RAY_DIR_Z * e2x - RAY_DIR_X * e2z;
        hz  = RAY_DIR_X * e2y - RAY_DIR_Y * e2x;
        qx  = sy * e1z - sz * e1y;
        qy  = sz * e1x - sx * e1z;
        qz  = sx * e1y - sy * e1x;
        det    = e1x * hx + e1y * hy + e1z * hz;
        bary_u = sx * hx + sy * hy + sz * hz;
        bary_v = RAY_DIR_X * qx + RAY_DIR_Y * qy + RAY_DIR_Z * qz;
        depth  = e2x * qx + e2y * qy + e2z * qz;
        if (det == 0) begin
            return 1'b0;
        end
        if (det < 0) begin
            det    = -det;
            bary_u = -bary_u;
            bary_v = -bary_v;
            depth  = -depth;
        end
        return (bary_u >= 0) && (bary_v >= 0) && (bary_u + bary_v <= det) && (depth > 0);
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                expected_hits = {expected_hits, ray_hits_triangle(
                    i_origin_x, i_origin_y, i_origin_z,
                    i_vert0_x, i_vert0_y, i_vert0_z,
                    i_vert1_x, i_vert1_y, i_vert1_z,
                    i_vert2_x, i_vert2_y, i_vert2_z)};
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_hits.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result hit=%b with no request outstanding", $time, i_hit);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (i_hit !== want) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: hit expected %b, got %b", $time, want, i_hit);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_fail_count    <= mismatch_count;
        o_pending_count <= expected_hits.size();
    end

endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for the ray/triangle hit test unit, with the result checker beside it.
`timescale 1ns / 100ps

module tb;

    typedef rth_pkg::t_coord t_request [12];

    localparam int DX = 16777216;
    localparam int DY = 2852;
    localparam int DZ = 5201;
    localparam int ONE = 65536;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_ready = 1'b0;
    rth_pkg::t_coord i_origin_x = '0;
    rth_pkg::t_coord i_origin_y = '0;
    rth_pkg::t_coord i_origin_z = '0;
    rth_pkg::t_coord i_vert0_x = '0;
    rth_pkg::t_coord i_vert0_y = '0;
    rth_pkg::t_coord i_vert0_z = '0;
    rth_pkg::t_coord i_vert1_x = '0;
    rth_pkg::t_coord i_vert1_y = '0;
    rth_pkg::t_coord i_vert1_z = '0;
    rth_pkg::t_coord i_vert2_x = '0;
    rth_pkg::t_coord i_vert2_y = '0;
    rth_pkg::t_coord i_vert2_z = '0;
    logic            o_ready;
    logic            o_valid;
    logic            o_hit;
    int              fail_count;
    int              pending_count;
    int              sent_count = 0;
    logic            held_off = 1'b0;

    ray_triangle_hit_test_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_vert0_x  (i_vert0_x),
        .i_vert0_y  (i_vert0_y),
        .i_vert0_z  (i_vert0_z),
        .i_vert1_x  (i_vert1_x),
        .i_vert1_y  (i_vert1_y),
        .i_vert1_z  (i_vert1_z),
        .i_vert2_x  (i_vert2_x),
        .i_vert2_y  (i_vert2_y),
        .i_vert2_z  (i_vert2_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit)
    );

    ray_triangle_hit_checker hit_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_vert0_x       (i_vert0_x),
        .i_vert0_y       (i_vert0_y),
        .i_vert0_z       (i_vert0_z),
        .i_vert1_x       (i_vert1_x),
        .i_vert1_y       (i_vert1_y),
        .i_vert1_z       (i_vert1_z),
        .i_vert2_x       (i_vert2_x),
        .i_vert2_y       (i_vert2_y),
        .i_vert2_z       (i_vert2_z),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_hit           (o_hit),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_pm(int unsigned half);
        return int'($urandom_range(2 * half)) - int'(half);
    endfunction

    function automatic t_request make_req(int ox, int oy, int oz, int ax, int ay, int az,
                                          int bx, int by, int bz, int cx, int cy, int cz);
        return '{ox, oy, oz, ax, ay, az, bx, by, bz, cx, cy, cz};
    endfunction

    function automatic t_request random_request();
        int       dir[3] = '{DX, DY, DZ};
        int       o[3];
        int       p[3];
        int       w[3];
        int       v[3][3];
        int       kind;
        int       spread;
        int       d;
        int       k;
        int       m;
        int       n;
        int       pick;
        t_request r;
        kind = $urandom_range(99);
        spread = 1 << $urandom_range(8, 20);
        for (int j = 0; j < 3; j++) begin
            o[j] = rand_pm(1 << 29);
            w[j] = rand_pm(spread);
        end
        if (kind < 55) begin
            // A triangle placed across the ray, mostly ahead of the origin.
            d = ($urandom_range(9) < 8) ? int'($urandom_range(1, 1 << 24))
                                         : -int'($urandom_range(0, 1 << 22));
            for (int i = 0; i < 3; i++) begin
                v[i][0] = o[0] + d + ($urandom_range(1) ? 0 : rand_pm(ONE));
                v[i][1] = o[1] + rand_pm(spread);
                v[i][2] = o[2] + rand_pm(spread);
            end
        end else if (kind < 68) begin
            // Corners set about a point on the line of the ray: per coordinate, on it or mirrored about it.
            k = int'($urandom_range(72)) - 8;
            for (int j = 0; j < 3; j++) begin
                p[j] = o[j] + k * dir[j];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v[i][j] = p[j] + rand_pm(spread);
                end
            end
            pick = $urandom_range(2);
            for (int j = 0; j < 3; j++) begin
                if ($urandom_range(1)) begin
                    v[pick][j] = p[j];
                end else begin
                    v[pick][j] = p[j] - w[j];
                    v[(pick + 1) % 3][j] = p[j] + w[j];
                end
            end
        end else if (kind < 76) begin
            // Degenerate triangles: collinear corners or an edge along the ray.
            m = rand_pm(3);
            n = rand_pm(3);
            pick = $urandom_range(1);
            for (int j = 0; j < 3; j++) begin
                v[0][j] = o[j] + rand_pm(spread) + ((j == 0) ? (1 << 22) : 0);
                if (pick != 0) begin
                    v[1][j] = v[0][j] + m * dir[j] / 4;
                    v[2][j] = v[0][j] + rand_pm(spread);
                end else begin
                    v[1][j] = v[0][j] + m * w[j];
                    v[2][j] = v[0][j] + n * w[j];
                end
            end
            if (pick != 0) begin
                // Keep the edge exactly parallel to the ray.
                for (int j = 0; j < 3; j++) begin
                    v[1][j] = v[0][j] + m * dir[j];
                end
            end
        end else if (kind < 82) begin
            // The origin lies in the plane of the triangle.
            for (int i = 0; i < 3; i++) begin
                v[i][0] = o[0];
                v[i][1] = o[1] + rand_pm(spread);
                v[i][2] = o[2] + rand_pm(spread);
            end
        end else begin
            for (int i = 0; i < 12; i++) begin
                r[i] = $urandom;
            end
            return r;
        end
        return make_req(o[0], o[1], o[2], v[0][0], v[0][1], v[0][2],
                        v[1][0], v[1][1], v[1][2], v[2][0], v[2][1], v[2][2]);
    endfunction

    task automatic offer(input t_request r);
        int gap;
        gap = ((sent_count / 100) % 3 == 1) ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_origin_x <= r[0];
        i_origin_y <= r[1];
        i_origin_z <= r[2];
        i_vert0_x  <= r[3];
        i_vert0_y  <= r[4];
        i_vert0_z  <= r[5];
        i_vert1_x  <= r[6];
        i_vert1_y  <= r[7];
        i_vert1_z  <= r[8];
        i_vert2_x  <= r[9];
        i_vert2_y  <= r[10];
        i_vert2_z  <= r[11];
        do @(posedge i_clk); while (!o_ready);
        sent_count++;
    endtask

    initial begin
        int burst;
        int gap;
        repeat (5) @(posedge i_clk);
        forever begin
            if (!held_off && sent_count >= 300) begin
                // A long stall on the result side so that the pipeline fills and pushes back.
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            burst = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (burst) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        offer(make_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        offer(make_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                       32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
        offer(make_req(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                       32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                       32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
        // Plain hit with both windings, then behind, in plane and off to the side.
        offer(make_req(0, 0, 0, ONE, -ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE));
        offer(make_req(0, 0, 0, ONE, -ONE, -ONE, ONE, 0, ONE, ONE, ONE, -ONE));
        offer(make_req(0, 0, 0, -ONE, -ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE));
        offer(make_req(0, 0, 0, 0, -ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE));
        offer(make_req(0, 0, 0, ONE, 2 * ONE, -ONE, ONE, 4 * ONE, -ONE, ONE, 3 * ONE, ONE));
        // Collinear corners, and an edge parallel to the ray.
        offer(make_req(0, 0, 0, ONE, 0, 0, ONE, ONE, 0, ONE, 2 * ONE, 0));
        offer(make_req(0, 0, 0, 100, 200, 300, 100 + DX, 200 + DY, 300 + DZ, 100, 200 + ONE, 300));
        // The ray passes exactly through a corner, with both windings.
        offer(make_req(1000, -2000, 3000, 1000 + DX, -2000 + DY, 3000 + DZ,
                       200000, 70000, 0, 300000, -60000, 90000));
        offer(make_req(1000, -2000, 3000, 1000 + DX, -2000 + DY, 3000 + DZ,
                       300000, -60000, 90000, 200000, 70000, 0));
        // The ray passes exactly through the middle of an edge.
        offer(make_req(1000, -2000, 3000,
                       1000 + 2 * DX, -2000 + 2 * DY - ONE, 3000 + 2 * DZ,
                       1000 + 2 * DX, -2000 + 2 * DY + ONE, 3000 + 2 * DZ,
                       1000 + 2 * DX, -2000 + 2 * DY, 3000 + 2 * DZ + ONE));
        offer(make_req(1000, -2000, 3000,
                       1000 + 2 * DX + ONE, -2000 + 2 * DY - ONE, 3000 + 2 * DZ,
                       1000 + 2 * DX, -2000 + 2 * DY, 3000 + 2 * DZ - ONE,
                       1000 + 2 * DX, -2000 + 2 * DY, 3000 + 2 * DZ + ONE));
        // Origin ahead of the vertex on the ray: the corner lies behind, so a miss.
        offer(make_req(1000 + DX, -2000 + DY, 3000 + DZ, 1000, -2000, 3000,
                       200000, 70000, 0, 300000, -60000, 90000));
        // A large triangle far away at the top of the coordinate range.
        offer(make_req(32'h80000000, 0, 0, 32'h7fffffff, 32'hc0000000, 32'hc0000000,
                       32'h7fffffff, 32'h40000000, 32'hc0000000, 32'h7fffffff, 0, 32'h40000000));

        for (int n = 0; n < 900; n++) begin
            offer(random_request());
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
